[design/mpxr_pkg.sv]
// Shared types and constants for the multi-packet XOR reply receiver.
`default_nettype none

package mpxr_pkg;

    // Input item codes
    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_BYTE    = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_BLK_LEN       = 2'd0;
    localparam logic [1:0] REG_TRANSFER_SIZE = 2'd1;
    localparam logic [1:0] REG_SIZE_LISTING  = 2'd2;
    localparam logic [1:0] REG_RETRY_LIMIT   = 2'd3;

    // Register reset values
    localparam logic [10:0] BLK_LEN_RST     = 11'd256;
    localparam logic [3:0]  RETRY_LIMIT_RST = 4'd5;

    // Status bytes above this value report a camera error
    localparam logic [7:0] STATUS_ERR_ABOVE = 8'hE0;

    // Listing size: entries * 20 plus two header bytes
    localparam logic [23:0] LIST_ENTRY_BYTES = 24'd20;
    localparam logic [23:0] LIST_EXTRA_BYTES = 24'd2;

    // Output queue depth and pointer width
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    typedef enum logic [2:0] {
        ACT_PAYLOAD = 3'd0,
        ACT_ACK     = 3'd1,
        ACT_NAK     = 3'd2,
        ACT_RESEND  = 3'd3,
        ACT_DONE    = 3'd4,
        ACT_FAIL    = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'b01,
        PH_ACTIVE = 2'b10
    } t_phase;

    typedef struct packed {
        t_action    action;
        logic [7:0] payload;
        logic       fail_cause;
        logic       last;
    } t_result;

    // Up to two results from one item; the second only with the first
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

    typedef struct packed {
        logic [10:0] blk_len;
        logic [23:0] transfer_size;
        logic        size_from_listing;
        logic [3:0]  retry_limit;
    } t_cfg;

    function automatic t_result mk_result(t_action act, logic [7:0] pay,
                                          logic cause, logic last);
        t_result r;
        r.action     = act;
        r.payload    = pay;
        r.fail_cause = cause;
        r.last       = last;
        return r;
    endfunction

endpackage

`default_nettype wire

[design/mpxr_core.sv]
// Packet state and per-item decode: status, payload, checksum, ack/nak logic.
`default_nettype none

module mpxr_core #(
    parameter int MAX_BLOCK = 1024
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_go,
    input  wire logic [1:0]    i_mode,
    input  wire logic [7:0]    i_rx_byte,
    input  wire mpxr_pkg::t_cfg i_cfg,
    output mpxr_pkg::t_push    o_push
);

    localparam int POS_W = $clog2(MAX_BLOCK + 2);
    localparam logic [23:0] LIST_ENTRY_BYTES_L = mpxr_pkg::LIST_ENTRY_BYTES;
    localparam logic [23:0] LIST_EXTRA_BYTES_L = mpxr_pkg::LIST_EXTRA_BYTES;

    mpxr_pkg::t_phase r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_xor, n_xor;
    logic [7:0]       r_status, n_status;
    logic [15:0]      r_pkts, n_pkts;
    logic [23:0]      r_rem, n_rem;
    logic             r_known, n_known;
    logic [3:0]       r_retry, n_retry;
    logic [7:0]       r_cnt_hi, n_cnt_hi;

    logic [POS_W-1:0] bs, endpos, pos;
    logic             bs_ge2;
    logic [15:0]      entries;
    logic [23:0]      list_size;
    logic [23:0]      take;

    // Clamp block size and the current position to the packet end
    always_comb begin
        if ({21'd0, i_cfg.blk_len} > 32'(MAX_BLOCK)) begin
            bs = POS_W'(MAX_BLOCK);
        end else begin
            bs = POS_W'(i_cfg.blk_len);
        end
        endpos = (bs == '0) ? '0 : bs + POS_W'(1);
        pos    = (r_pos > endpos) ? endpos : r_pos;
        bs_ge2 = (bs >= POS_W'(2));
    end

    assign entries   = {r_cnt_hi, i_rx_byte};
    assign list_size = 24'(entries) * LIST_ENTRY_BYTES_L + LIST_EXTRA_BYTES_L;

    // Next state and results for one item
    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_xor    = r_xor;
        n_status = r_status;
        n_pkts   = r_pkts;
        n_rem    = r_rem;
        n_known  = r_known;
        n_retry  = r_retry;
        n_cnt_hi = r_cnt_hi;
        take     = '0;
        o_push.v0 = 1'b0;
        o_push.v1 = 1'b0;
        o_push.r0 = mpxr_pkg::mk_result(mpxr_pkg::ACT_PAYLOAD, 8'd0, 1'b0, 1'b1);
        o_push.r1 = mpxr_pkg::mk_result(mpxr_pkg::ACT_DONE, 8'd0, 1'b0, 1'b1);

        if (i_go) begin
            unique case (i_mode)
                mpxr_pkg::MODE_START: begin
                    // Restart the transfer from scratch
                    n_pos    = '0;
                    n_xor    = '0;
                    n_status = '0;
                    n_pkts   = '0;
                    n_rem    = '0;
                    n_known  = 1'b0;
                    n_retry  = '0;
                    n_cnt_hi = '0;
                    n_phase  = mpxr_pkg::PH_ACTIVE;
                    if (i_cfg.transfer_size != '0 && bs != '0 && !i_cfg.size_from_listing) begin
                        n_known = 1'b1;
                        n_rem   = i_cfg.transfer_size;
                    end
                end
                mpxr_pkg::MODE_TIMEOUT: begin
                    if (r_phase == mpxr_pkg::PH_ACTIVE) begin
                        // Drop the partial packet, then resend, nak or give up
                        n_pos = '0;
                        n_xor = '0;
                        o_push.v0 = 1'b1;
                        if (r_retry >= i_cfg.retry_limit) begin
                            n_phase   = mpxr_pkg::PH_IDLE;
                            o_push.r0 = mpxr_pkg::mk_result(mpxr_pkg::ACT_FAIL, 8'd0, 1'b1, 1'b1);
                        end else begin
                            n_retry = r_retry + 4'd1;
                            if (r_pkts == '0) begin
                                o_push.r0 = mpxr_pkg::mk_result(mpxr_pkg::ACT_RESEND, 8'd0,
                                                                1'b0, 1'b1);
                            end else begin
                                o_push.r0 = mpxr_pkg::mk_result(mpxr_pkg::ACT_NAK, 8'd0,
                                                                1'b0, 1'b1);
                            end
                        end
                    end
                end
                mpxr_pkg::MODE_BYTE: begin
                    if (r_phase == mpxr_pkg::PH_ACTIVE) begin
                        // Status byte, or payload byte with checksum and listing count
                        if (pos == '0) begin
                            n_status = i_rx_byte;
                            n_xor    = '0;
                        end else if (pos <= bs) begin
                            n_xor = r_xor ^ i_rx_byte;
                            if (i_cfg.size_from_listing && r_pkts == '0 && bs_ge2) begin
                                if (pos == POS_W'(1)) begin
                                    n_cnt_hi = i_rx_byte;
                                end else if (pos == POS_W'(2)) begin
                                    n_rem   = list_size;
                                    n_known = 1'b1;
                                end
                            end
                            if (!n_known || 24'(pos) <= n_rem) begin
                                o_push.v0 = 1'b1;
                                o_push.r0 = mpxr_pkg::mk_result(mpxr_pkg::ACT_PAYLOAD,
                                                                i_rx_byte, 1'b0, 1'b1);
                            end
                        end

                        if (pos < endpos) begin
                            n_pos = pos + POS_W'(1);
                        end else begin
                            // End of packet: check, then nak, fail, finish, or ack and maybe finish
                            n_pos = '0;
                            o_push.v0 = 1'b1;
                            if (bs_ge2 && i_rx_byte != n_xor) begin
                                o_push.r0 = mpxr_pkg::mk_result(mpxr_pkg::ACT_NAK, 8'd0,
                                                                1'b0, 1'b1);
                            end else if (n_status > mpxr_pkg::STATUS_ERR_ABOVE) begin
                                n_phase   = mpxr_pkg::PH_IDLE;
                                o_push.r0 = mpxr_pkg::mk_result(mpxr_pkg::ACT_FAIL, 8'd0,
                                                                1'b0, 1'b1);
                            end else if (n_status == '0) begin
                                n_phase   = mpxr_pkg::PH_IDLE;
                                o_push.r0 = mpxr_pkg::mk_result(mpxr_pkg::ACT_DONE, 8'd0,
                                                                1'b0, 1'b1);
                            end else begin
                                n_retry = '0;
                                if (r_pkts != 16'hFFFF) begin
                                    n_pkts = r_pkts + 16'd1;
                                end
                                o_push.r0 = mpxr_pkg::mk_result(mpxr_pkg::ACT_ACK, 8'd0,
                                                                1'b0, 1'b1);
                                if (n_known) begin
                                    take  = (24'(bs) < n_rem) ? 24'(bs) : n_rem;
                                    n_rem = n_rem - take;
                                    if (n_rem == '0) begin
                                        n_phase      = mpxr_pkg::PH_IDLE;
                                        o_push.r0.last = 1'b0;
                                        o_push.v1    = 1'b1;
                                    end
                                end else if (n_pkts >= 16'd2) begin
                                    n_phase        = mpxr_pkg::PH_IDLE;
                                    o_push.r0.last = 1'b0;
                                    o_push.v1      = 1'b1;
                                end
                            end
                        end
                    end
                end
                default: begin
                    // Unused code: ignore
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= mpxr_pkg::PH_IDLE;
            r_pos    <= '0;
            r_xor    <= '0;
            r_status <= '0;
            r_pkts   <= '0;
            r_rem    <= '0;
            r_known  <= 1'b0;
            r_retry  <= '0;
            r_cnt_hi <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_xor    <= n_xor;
            r_status <= n_status;
            r_pkts   <= n_pkts;
            r_rem    <= n_rem;
            r_known  <= n_known;
            r_retry  <= n_retry;
            r_cnt_hi <= n_cnt_hi;
        end
    end

endmodule

`default_nettype wire

[design/mpxr_outq.sv]
// Result queue: takes one or two results per cycle, hands out one per transfer.
`default_nettype none

module mpxr_outq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mpxr_pkg::t_push i_push,
    output logic                o_room,
    output logic                o_valid,
    input  wire logic           i_stall,
    output mpxr_pkg::t_result   o_head
);

    localparam int CNT_W = mpxr_pkg::QPTR_W + 1;

    mpxr_pkg::t_result r_mem [mpxr_pkg::QDEPTH];
    logic [mpxr_pkg::QPTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic                        pop;
    logic [1:0]                  npush;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && !i_stall;
    assign o_head  = r_mem[r_rp];
    // Room for the worst case of two results
    assign o_room  = (r_cnt <= CNT_W'(mpxr_pkg::QDEPTH - 2));
    assign npush   = {1'b0, i_push.v0} + {1'b0, i_push.v1};
    assign n_cnt   = r_cnt + CNT_W'(npush) - CNT_W'(pop);

    // Write results at the tail
    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[r_wp + mpxr_pkg::QPTR_W'(1)] <= i_push.r1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + mpxr_pkg::QPTR_W'(npush);
            r_cnt <= n_cnt;
            if (pop) begin
                r_rp <= r_rp + mpxr_pkg::QPTR_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

[design/multi_packet_xor_receiver_unit.sv]
// Top level of the multi-packet XOR reply receiver: input stage, registers, core, queue.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------
//  in       | in        | i_valid / o_stall  | i_mode, i_rx_byte
//  out      | out       | o_valid / i_stall  | o_action, o_payload, o_fail_cause, o_last
//  config   | in        | APB psel/penable   | paddr, pwdata, prdata, pready
//
// One item is taken every cycle while the input does not stall; each item waits in the input
// register until the queue has room, the core decodes it, and its results enter the queue.
// An item that yields ack and finished occupies the output for two transfers.
// Reset is synchronous, active low; it empties the queue and sets the registers.
// The input stalls only when the four-entry result queue lacks room for two results.
`default_nettype none

module multi_packet_xor_receiver_unit #(
    parameter int MAX_BLOCK = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [7:0]  i_rx_byte,
    // Output channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_action,
    output logic [7:0]       o_payload,
    output logic             o_fail_cause,
    output logic             o_last,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic        r_in_valid;
    logic [1:0]  r_mode;
    logic [7:0]  r_rx_byte;
    logic        go;
    logic        room;
    logic        cfg_wr;

    logic [10:0] r_blk_len;
    logic [23:0] r_transfer_size;
    logic        r_size_listing;
    logic [3:0]  r_retry_limit;

    mpxr_pkg::t_cfg    cfg;
    mpxr_pkg::t_push   push;
    mpxr_pkg::t_result head;

    // Register file writes
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_len       <= mpxr_pkg::BLK_LEN_RST;
            r_transfer_size <= '0;
            r_size_listing  <= 1'b0;
            r_retry_limit   <= mpxr_pkg::RETRY_LIMIT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                mpxr_pkg::REG_BLK_LEN:       r_blk_len       <= pwdata[10:0];
                mpxr_pkg::REG_TRANSFER_SIZE: r_transfer_size <= pwdata[23:0];
                mpxr_pkg::REG_SIZE_LISTING:  r_size_listing  <= pwdata[0];
                mpxr_pkg::REG_RETRY_LIMIT:   r_retry_limit   <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (paddr[3:2])
            mpxr_pkg::REG_BLK_LEN:       prdata = {21'd0, r_blk_len};
            mpxr_pkg::REG_TRANSFER_SIZE: prdata = {8'd0, r_transfer_size};
            mpxr_pkg::REG_SIZE_LISTING:  prdata = {31'd0, r_size_listing};
            mpxr_pkg::REG_RETRY_LIMIT:   prdata = {28'd0, r_retry_limit};
            default:                     prdata = '0;
        endcase
    end

    assign cfg.blk_len           = r_blk_len;
    assign cfg.transfer_size     = r_transfer_size;
    assign cfg.size_from_listing = r_size_listing;
    assign cfg.retry_limit       = r_retry_limit;

    // Input register: hold while the queue lacks room
    assign go      = r_in_valid && room;
    assign o_stall = r_in_valid && !room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_mode    <= i_mode;
            r_rx_byte <= i_rx_byte;
        end
    end

    mpxr_core #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (go),
        .i_mode    (r_mode),
        .i_rx_byte (r_rx_byte),
        .i_cfg     (cfg),
        .o_push    (push)
    );

    mpxr_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_head  (head)
    );

    assign o_action     = head.action;
    assign o_payload    = head.payload;
    assign o_fail_cause = head.fail_cause;
    assign o_last       = head.last;

endmodule

`default_nettype wire

[design/mpxr_checker.sv]
// Port-level checks on the receiver's result stream, bound to the top level.
`default_nettype none

module mpxr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_stall,
    input wire logic       o_valid,
    input wire logic [2:0] o_action,
    input wire logic [7:0] o_payload,
    input wire logic       o_fail_cause,
    input wire logic       o_last
);

    // Queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    // Only an ack is followed by a second result of the same item
    a_first_is_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_action == mpxr_pkg::ACT_ACK)
        else $error("non-last result is not an ack");

    // The result after a non-last ack is finished, ready at once
    a_ack_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid && o_action == mpxr_pkg::ACT_DONE && o_last)
        else $error("ack pair not completed by finished");

    // Cause and payload are clear outside their own actions
    a_side_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_fail_cause || o_action == mpxr_pkg::ACT_FAIL) &&
                    (o_payload == 8'd0 || o_action == mpxr_pkg::ACT_PAYLOAD))
        else $error("side field set for wrong action");

endmodule

bind multi_packet_xor_receiver_unit mpxr_checker u_mpxr_checker (.*);

`default_nettype wire

[sim/tb.sv]
// Testbench for the multi-packet XOR reply receiver: random packet traffic against a predictor.
`timescale 1ns / 1ps

module tb;

    localparam int MAX_BLOCK = 1024;
    localparam int ITEM_TARGET = 1400;
    // Mode code with no meaning to the block; used as noise
    localparam logic [1:0] MODE_NONE = 2'd3;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_EVERY_THIRD,
        STALL_HEAVY
    } t_stall_style;

    // Track receiver state and the results it owes
    class t_reply_tracker;
        logic [10:0] blk_size;
        logic [23:0] xfer_size;
        logic        listing;
        logic [3:0]  retry_lim;

        mpxr_pkg::t_phase phase;
        logic [10:0] pos;
        logic [7:0]  xor_acc;
        logic [7:0]  status;
        logic [15:0] pkts_done;
        logic [23:0] remaining;
        logic        size_known;
        logic [3:0]  retries;
        logic [7:0]  count_hi;

        mpxr_pkg::t_result awaited_results[$];
        int          mismatches;

        function new();
            blk_size   = mpxr_pkg::BLK_LEN_RST;
            xfer_size  = '0;
            listing    = 1'b0;
            retry_lim  = mpxr_pkg::RETRY_LIMIT_RST;
            phase      = mpxr_pkg::PH_IDLE;
            mismatches = 0;
            clear_transfer();
        endfunction

        function void clear_transfer();
            pos        = '0;
            xor_acc    = '0;
            status     = '0;
            pkts_done  = '0;
            remaining  = '0;
            size_known = 1'b0;
            retries    = '0;
            count_hi   = '0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] value);
            unique case (idx)
                mpxr_pkg::REG_BLK_LEN:       blk_size  = value[10:0];
                mpxr_pkg::REG_TRANSFER_SIZE: xfer_size = value[23:0];
                mpxr_pkg::REG_SIZE_LISTING:  listing   = value[0];
                mpxr_pkg::REG_RETRY_LIMIT:   retry_lim = value[3:0];
                default: ;
            endcase
        endfunction

        function logic [10:0] block_eff();
            return (blk_size > MAX_BLOCK) ? 11'(MAX_BLOCK) : blk_size;
        endfunction

        function void add_result(mpxr_pkg::t_action act, logic [7:0] pay, logic cause,
                                 logic lst);
            mpxr_pkg::t_result r;
            r.action     = act;
            r.payload    = pay;
            r.fail_cause = cause;
            r.last       = lst;
            awaited_results.push_back(r);
        endfunction

        // Advance the model by one accepted transfer; return 0 if the block ignores it
        function bit take_item(logic [1:0] mode, logic [7:0] b);
            logic [10:0] bs;
            logic [10:0] endpos;
            logic [10:0] p;
            logic [23:0] take;
            if (mode == mpxr_pkg::MODE_START) begin
                clear_transfer();
                bs = block_eff();
                if (xfer_size != 0 && bs != 0 && !listing) begin
                    size_known = 1'b1;
                    remaining  = xfer_size;
                end
                phase = mpxr_pkg::PH_ACTIVE;
                return 1'b1;
            end
            if (phase != mpxr_pkg::PH_ACTIVE ||
                !(mode == mpxr_pkg::MODE_BYTE || mode == mpxr_pkg::MODE_TIMEOUT))
                return 1'b0;

            // Timeout: drop the partial packet, resend or nak until retries run out
            if (mode == mpxr_pkg::MODE_TIMEOUT) begin
                pos     = '0;
                xor_acc = '0;
                if (retries >= retry_lim) begin
                    phase = mpxr_pkg::PH_IDLE;
                    add_result(mpxr_pkg::ACT_FAIL, 8'h00, 1'b1, 1'b1);
                    return 1'b1;
                end
                retries = retries + 4'd1;
                add_result(pkts_done == 0 ? mpxr_pkg::ACT_RESEND : mpxr_pkg::ACT_NAK,
                           8'h00, 1'b0, 1'b1);
                return 1'b1;
            end

            bs     = block_eff();
            endpos = (bs == 0) ? 11'd0 : bs + 11'd1;
            // A lowered block size turns an overrun position into the packet's end
            p      = (pos > endpos) ? endpos : pos;

            if (p == 0) begin
                status  = b;
                xor_acc = '0;
            end else if (p <= bs) begin
                xor_acc ^= b;
                if (listing && pkts_done == 0 && bs >= 2) begin
                    if (p == 1) begin
                        count_hi = b;
                    end else if (p == 2) begin
                        remaining  = 24'({count_hi, b}) * mpxr_pkg::LIST_ENTRY_BYTES +
                                     mpxr_pkg::LIST_EXTRA_BYTES;
                        size_known = 1'b1;
                    end
                end
                if (!size_known || 24'(p) <= remaining)
                    add_result(mpxr_pkg::ACT_PAYLOAD, b, 1'b0, 1'b1);
            end

            if (p < endpos) begin
                pos = p + 11'd1;
                return 1'b1;
            end

            // End of packet: checksum, status, then commit
            pos = '0;
            if (bs >= 2 && b != xor_acc) begin
                add_result(mpxr_pkg::ACT_NAK, 8'h00, 1'b0, 1'b1);
                return 1'b1;
            end
            if (status > mpxr_pkg::STATUS_ERR_ABOVE) begin
                phase = mpxr_pkg::PH_IDLE;
                add_result(mpxr_pkg::ACT_FAIL, 8'h00, 1'b0, 1'b1);
                return 1'b1;
            end
            if (status == 0) begin
                phase = mpxr_pkg::PH_IDLE;
                add_result(mpxr_pkg::ACT_DONE, 8'h00, 1'b0, 1'b1);
                return 1'b1;
            end
            retries = '0;
            if (pkts_done != 16'hFFFF)
                pkts_done = pkts_done + 16'd1;
            if (size_known) begin
                take      = (24'(bs) < remaining) ? 24'(bs) : remaining;
                remaining = remaining - take;
                if (remaining == 0) begin
                    phase = mpxr_pkg::PH_IDLE;
                    add_result(mpxr_pkg::ACT_ACK, 8'h00, 1'b0, 1'b0);
                    add_result(mpxr_pkg::ACT_DONE, 8'h00, 1'b0, 1'b1);
                    return 1'b1;
                end
            end else if (pkts_done >= 2) begin
                phase = mpxr_pkg::PH_IDLE;
                add_result(mpxr_pkg::ACT_ACK, 8'h00, 1'b0, 1'b0);
                add_result(mpxr_pkg::ACT_DONE, 8'h00, 1'b0, 1'b1);
                return 1'b1;
            end
            add_result(mpxr_pkg::ACT_ACK, 8'h00, 1'b0, 1'b1);
            return 1'b1;
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $time, msg);
        endfunction

        // Compare one output transfer against the oldest awaited result
        function void match_result(logic [2:0] act, logic [7:0] pay, logic cause, logic lst);
            mpxr_pkg::t_result want;
            if (awaited_results.size() == 0) begin
                note_mismatch($sformatf({"unexpected result action=%0d payload=%02h ",
                                         "cause=%0b last=%0b"}, act, pay, cause, lst));
                return;
            end
            want = awaited_results.pop_front();
            if (want.action !== act || want.payload !== pay ||
                want.fail_cause !== cause || want.last !== lst)
                note_mismatch($sformatf({"expected action=%0d payload=%02h cause=%0b last=%0b, ",
                                         "got action=%0d payload=%02h cause=%0b last=%0b"},
                                        want.action, want.payload, want.fail_cause, want.last,
                                        act, pay, cause, lst));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_mode = mpxr_pkg::MODE_START;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_action;
    logic [7:0]  o_payload;
    logic        o_fail_cause;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'h0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    t_reply_tracker tracker = new();
    int           burst_left = 0;
    int           items_taken = 0;
    bit           long_hold_req = 1'b0;

    multi_packet_xor_receiver_unit #(
        .MAX_BLOCK(MAX_BLOCK)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_mode(i_mode),
        .i_rx_byte(i_rx_byte),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_action(o_action),
        .o_payload(o_payload),
        .o_fail_cause(o_fail_cause),
        .o_last(o_last),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // Offer one item in bursts with random gaps; hold it until the transfer
    task automatic send_item(logic [1:0] mode, logic [7:0] b);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        i_valid   <= 1'b1;
        i_mode    <= mode;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (tracker.take_item(mode, b))
            items_taken++;
        burst_left--;
    endtask

    // Drop valid and wait until every awaited result has come out
    task automatic settle();
        i_valid <= 1'b0;
        burst_left = 0;
        while (tracker.awaited_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write one register: setup cycle, then access cycle
    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_register(idx, value);
    endtask

    task automatic set_config(logic [10:0] bs, logic [23:0] ts, logic lst, logic [3:0] rl);
        settle();
        apb_write(mpxr_pkg::REG_BLK_LEN, 32'(bs));
        apb_write(mpxr_pkg::REG_TRANSFER_SIZE, 32'(ts));
        apb_write(mpxr_pkg::REG_SIZE_LISTING, 32'(lst));
        apb_write(mpxr_pkg::REG_RETRY_LIMIT, 32'(rl));
    endtask

    // Send status, payload and checksum; first-packet listing counts kept small
    task automatic send_packet(logic [7:0] st, bit corrupt);
        logic [10:0] n;
        logic [7:0]  x;
        logic [7:0]  d;
        n = tracker.block_eff();
        x = 8'h00;
        send_item(mpxr_pkg::MODE_BYTE, st);
        for (int i = 1; i <= n; i++) begin
            d = 8'($urandom_range(0, 255));
            if (tracker.listing && tracker.pkts_done == 0 && n >= 2 && i <= 2 &&
                $urandom_range(0, 7) != 0)
                d = (i == 1) ? 8'h00 : 8'($urandom_range(0, 4));
            send_item(mpxr_pkg::MODE_BYTE, d);
            x ^= d;
        end
        if (n != 0)
            send_item(mpxr_pkg::MODE_BYTE, corrupt ? x ^ 8'($urandom_range(1, 255)) : x);
    endtask

    // Check every output transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            tracker.match_result(o_action, o_payload, o_fail_cause, o_last);
    end

    // Receiver stall pattern, with a long hold-off on request
    initial begin
        t_stall_style style;
        int           seg_left;
        int           tick;
        style    = STALL_NONE;
        seg_left = 0;
        tick     = 0;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    style    = t_stall_style'($urandom_range(0, 3));
                    seg_left = $urandom_range(5, 80);
                end
                seg_left--;
                tick++;
                unique case (style)
                    STALL_NONE:        i_stall <= 1'b0;
                    STALL_LIGHT:       i_stall <= ($urandom_range(0, 99) < 35);
                    STALL_EVERY_THIRD: i_stall <= (tick % 3 == 0);
                    default:           i_stall <= ($urandom_range(0, 99) < 85);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Stimulus
    initial begin
        int          iter;
        int          pick;
        int          wait_cycles;
        logic [10:0] n;
        logic [10:0] new_bs;
        logic [23:0] xfer;
        logic [7:0]  st;
        logic [1:0]  stray_mode;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Status-only packets: ignored items, restart, pair result, error and finish
        set_config(11'd0, 24'hFFFFFF, 1'b1, 4'd0);
        send_item(mpxr_pkg::MODE_BYTE, 8'hFF);
        send_item(mpxr_pkg::MODE_TIMEOUT, 8'h00);
        send_item(MODE_NONE, 8'hAA);
        send_item(mpxr_pkg::MODE_START, 8'h00);
        send_item(mpxr_pkg::MODE_BYTE, 8'h05);
        send_item(mpxr_pkg::MODE_START, 8'h55);
        send_item(mpxr_pkg::MODE_BYTE, mpxr_pkg::STATUS_ERR_ABOVE);
        send_item(mpxr_pkg::MODE_BYTE, 8'h7F);
        send_item(mpxr_pkg::MODE_START, 8'h00);
        send_item(mpxr_pkg::MODE_TIMEOUT, 8'h00);
        send_item(mpxr_pkg::MODE_START, 8'h00);
        send_item(mpxr_pkg::MODE_BYTE, 8'h00);
        send_item(mpxr_pkg::MODE_START, 8'h00);
        send_item(mpxr_pkg::MODE_BYTE, 8'hFF);

        // Two-byte packets: resend, good packet, nak on timeout, bad checksum
        set_config(11'd2, 24'd3, 1'b0, 4'd15);
        send_item(mpxr_pkg::MODE_START, 8'h00);
        send_item(mpxr_pkg::MODE_TIMEOUT, 8'h00);
        send_item(mpxr_pkg::MODE_BYTE, 8'h01);
        send_item(mpxr_pkg::MODE_BYTE, 8'h00);
        send_item(mpxr_pkg::MODE_BYTE, 8'hFF);
        send_item(mpxr_pkg::MODE_BYTE, 8'hFF);
        send_item(mpxr_pkg::MODE_TIMEOUT, 8'h00);
        send_item(mpxr_pkg::MODE_BYTE, 8'h02);
        send_item(mpxr_pkg::MODE_BYTE, 8'hA5);
        send_item(mpxr_pkg::MODE_BYTE, 8'h5A);
        send_item(mpxr_pkg::MODE_BYTE, 8'h00);

        // One packet at the largest block size, truncated by the transfer size
        set_config(11'h7FF, 24'd300, 1'b0, 4'($urandom_range(0, 15)));
        send_item(mpxr_pkg::MODE_START, 8'($urandom_range(0, 255)));
        send_packet(8'h01, 1'b0);

        // Random transfers until the item budget is spent
        iter = 0;
        while (items_taken < ITEM_TARGET) begin
            iter++;
            if (iter == 1 || $urandom_range(0, 3) == 0) begin
                pick = $urandom_range(0, 19);
                if (pick < 2)       new_bs = 11'd0;
                else if (pick < 4)  new_bs = 11'd1;
                else if (pick < 12) new_bs = 11'($urandom_range(2, 4));
                else if (pick < 19) new_bs = 11'($urandom_range(5, 16));
                else                new_bs = 11'($urandom_range(17, 40));
                pick = $urandom_range(0, 19);
                if (pick < 6)       xfer = 24'd0;
                else if (pick == 6) xfer = 24'hFFFFFF;
                else if (pick == 7) xfer = 24'($urandom);
                else                xfer = 24'($urandom_range(1, 40));
                set_config(new_bs, xfer, $urandom_range(0, 9) < 3, 4'($urandom_range(0, 15)));
            end
            send_item(mpxr_pkg::MODE_START, 8'($urandom_range(0, 255)));
            if (iter % 20 == 1)
                long_hold_req = 1'b1;

            for (int k = 0; k < 24 && tracker.phase == mpxr_pkg::PH_ACTIVE &&
                            items_taken < ITEM_TARGET; k++) begin
                pick = $urandom_range(0, 19);
                if (pick == 0)      st = 8'h00;
                else if (pick == 1) st = 8'($urandom_range(8'hE1, 8'hFF));
                else if (pick == 2) st = mpxr_pkg::STATUS_ERR_ABOVE;
                else                st = 8'($urandom_range(1, 8'hDF));
                n = tracker.block_eff();
                pick = $urandom_range(0, 99);
                if (pick < 66) begin
                    send_packet(st, 1'b0);
                end else if (pick < 74) begin
                    send_packet(st, 1'b1);
                end else if (pick < 84) begin
                    // Partial packet cut short by a timeout
                    send_item(mpxr_pkg::MODE_BYTE, st);
                    repeat ($urandom_range(0, n))
                        send_item(mpxr_pkg::MODE_BYTE, 8'($urandom_range(0, 255)));
                    send_item(mpxr_pkg::MODE_TIMEOUT, 8'($urandom_range(0, 255)));
                end else if (pick < 88) begin
                    send_item(mpxr_pkg::MODE_TIMEOUT, 8'($urandom_range(0, 255)));
                end else if (pick < 92) begin
                    send_item(MODE_NONE, 8'($urandom_range(0, 255)));
                end else if (pick < 94) begin
                    send_item(mpxr_pkg::MODE_START, 8'($urandom_range(0, 255)));
                end else if (pick < 97) begin
                    // Lower the block size in the middle of a packet
                    if (n >= 3) begin
                        send_item(mpxr_pkg::MODE_BYTE, st);
                        new_bs = 11'($urandom_range(1, n));
                        repeat (new_bs)
                            send_item(mpxr_pkg::MODE_BYTE, 8'($urandom_range(0, 255)));
                        settle();
                        apb_write(mpxr_pkg::REG_BLK_LEN, 32'($urandom_range(0, new_bs - 1)));
                        send_item(mpxr_pkg::MODE_BYTE, 8'($urandom_range(0, 255)));
                    end
                end else begin
                    // Change the block size between packets, zero included
                    settle();
                    apb_write(mpxr_pkg::REG_BLK_LEN, 32'($urandom_range(0, 8)));
                end
            end

            // Stray item after the transfer
            if ($urandom_range(0, 4) == 0) begin
                pick = $urandom_range(0, 2);
                if (pick == 0)      stray_mode = mpxr_pkg::MODE_BYTE;
                else if (pick == 1) stray_mode = mpxr_pkg::MODE_TIMEOUT;
                else                stray_mode = MODE_NONE;
                send_item(stray_mode, 8'($urandom_range(0, 255)));
            end
        end

        // Drain the remaining results, then let the pipeline empty
        i_valid <= 1'b0;
        wait_cycles = 0;
        while (tracker.awaited_results.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (10) @(posedge i_clk);
        if (tracker.awaited_results.size() != 0)
            tracker.note_mismatch($sformatf("%0d results never arrived",
                                            tracker.awaited_results.size()));

        if (tracker.mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Hard stop
    initial begin
        #(10_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
